### hw/rtl/frp_pkg.sv
// Types and constants shared by the FASTA record parser modules.
// No dependencies; imported by frp_step and fasta_record_parser_core.
`timescale 1ns / 1ps

package frp_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Result kinds.
  localparam logic [1:0] KIND_NONE       = 2'd0;
  localparam logic [1:0] KIND_LABEL      = 2'd1;
  localparam logic [1:0] KIND_SITE       = 2'd2;
  localparam logic [1:0] KIND_RECORD_END = 2'd3;

  // Error codes.
  localparam logic [3:0] ERR_OK             = 4'd0;
  localparam logic [3:0] ERR_NO_GT          = 4'd1;
  localparam logic [3:0] ERR_EMPTY_LABEL    = 4'd2;
  localparam logic [3:0] ERR_BAD_LABEL_END  = 4'd3;
  localparam logic [3:0] ERR_NO_SEQUENCE    = 4'd4;
  localparam logic [3:0] ERR_INVALID_SYMBOL = 4'd5;
  localparam logic [3:0] ERR_EMPTY_LINE     = 4'd6;
  localparam logic [3:0] ERR_NO_FINAL_NL    = 4'd7;
  localparam logic [3:0] ERR_EMPTY_SEQUENCE = 4'd8;

  // Casing modes.
  localparam logic [1:0] CASE_KEEP  = 2'd0;
  localparam logic [1:0] CASE_UPPER = 2'd1;
  localparam logic [1:0] CASE_LOWER = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_CASING   = 3'd0;
  localparam logic [2:0] REG_VALIDATE = 3'd1;
  localparam logic [2:0] REG_MAP_0    = 3'd2;
  localparam logic [2:0] REG_MAP_1    = 3'd3;
  localparam logic [2:0] REG_MAP_2    = 3'd4;
  localparam logic [2:0] REG_MAP_3    = 3'd5;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_LABEL_FIRST = 3'd1,
    PH_LABEL       = 3'd2,
    PH_SEQ_FIRST   = 3'd3,
    PH_COMMENT     = 3'd4,
    PH_SITES       = 3'd5,
    PH_DONE        = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       record_has_site;
    logic       line_has_char;
    logic [3:0] sticky_error;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]   casing_mode;
    logic         validate_enable;
    logic [255:0] valid_map;
  } parse_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] error_code;
    logic       line_inc;
  } step_result_t;

endpackage

### hw/rtl/frp_step.sv
// Per-byte decision logic of the FASTA record parser: next parse state and result.
// Depends on frp_pkg.
`timescale 1ns / 1ps

module frp_step
  import frp_pkg::*;
(
  input  parse_state_t cur,
  input  parse_cfg_t   cfg,
  input  logic [7:0]   text_byte,
  input  logic         end_of_stream,
  output parse_state_t nxt,
  output step_result_t res
);

  logic       printable;
  logic [7:0] site_ch;
  logic [3:0] err;
  logic [1:0] kind;
  logic [7:0] ch;

  assign printable = (text_byte >= CH_PRINT_LO) && (text_byte <= CH_PRINT_HI);

  always_comb begin
    site_ch = text_byte;
    if (cfg.casing_mode == CASE_UPPER && text_byte >= 8'h61 && text_byte <= 8'h7A) begin
      site_ch = text_byte - 8'h20;
    end else if (cfg.casing_mode == CASE_LOWER && text_byte >= 8'h41
                 && text_byte <= 8'h5A) begin
      site_ch = text_byte + 8'h20;
    end
  end

  always_comb begin
    nxt  = cur;
    kind = KIND_NONE;
    ch   = 8'h00;
    err  = ERR_OK;
    res  = '0;
    if (cur.sticky_error == ERR_OK && cur.phase != PH_DONE) begin
      unique case (cur.phase)
        PH_START: begin
          if (end_of_stream) nxt.phase = PH_DONE;
          else if (text_byte == CH_GT) nxt.phase = PH_LABEL_FIRST;
          else err = ERR_NO_GT;
        end
        PH_LABEL_FIRST: begin
          if (!end_of_stream && printable) begin
            kind = KIND_LABEL;
            ch = text_byte;
            nxt.phase = PH_LABEL;
          end else begin
            err = ERR_EMPTY_LABEL;
          end
        end
        PH_LABEL: begin
          if (end_of_stream) err = ERR_BAD_LABEL_END;
          else if (printable) begin
            kind = KIND_LABEL;
            ch = text_byte;
          end else if (text_byte == CH_NL) nxt.phase = PH_SEQ_FIRST;
          else err = ERR_BAD_LABEL_END;
        end
        PH_COMMENT: begin
          if (end_of_stream) err = ERR_NO_SEQUENCE;
          else if (text_byte == CH_NL) nxt.phase = PH_SEQ_FIRST;
        end
        default: begin
          // Start of the first line after the label: comments, or the checks
          // for a record with no sequence at all.
          if (cur.phase == PH_SEQ_FIRST && !cur.line_has_char
              && (end_of_stream || text_byte == CH_SEMI || text_byte == CH_GT)) begin
            if (end_of_stream) err = ERR_NO_SEQUENCE;
            else if (text_byte == CH_SEMI) nxt.phase = PH_COMMENT;
            else err = ERR_EMPTY_SEQUENCE;
          end else if (!cur.line_has_char && (end_of_stream || text_byte == CH_GT)) begin
            kind = KIND_RECORD_END;
            nxt.record_has_site = 1'b0;
            nxt.phase = end_of_stream ? PH_DONE : PH_LABEL_FIRST;
          end else if (!cur.line_has_char && text_byte == CH_NL) begin
            err = ERR_EMPTY_LINE;
          end else if (cur.line_has_char && end_of_stream) begin
            err = ERR_NO_FINAL_NL;
          end else if (cur.line_has_char && text_byte == CH_NL) begin
            nxt.line_has_char = 1'b0;
            nxt.phase = PH_SITES;
          end else if (cfg.validate_enable && !cfg.valid_map[site_ch]) begin
            err = ERR_INVALID_SYMBOL;
          end else begin
            kind = KIND_SITE;
            ch = site_ch;
            nxt.line_has_char = 1'b1;
            nxt.record_has_site = 1'b1;
            nxt.phase = PH_SITES;
          end
        end
      endcase
      if (err != ERR_OK) begin
        nxt = cur;
        nxt.sticky_error = err;
        kind = KIND_NONE;
        ch = 8'h00;
      end else begin
        res.line_inc = !end_of_stream && (text_byte == CH_NL);
      end
    end
    res.kind = kind;
    res.ch = ch;
    res.error_code = nxt.sticky_error;
  end

endmodule

### hw/rtl/fasta_record_parser_core.sv
// Top level of the FASTA record parser: stream ports, configuration registers,
// parse state, line counter and output register. Depends on frp_pkg and frp_step.
`timescale 1ns / 1ps

// The parser takes one transaction per clock cycle: each text byte (or the
// end-of-stream marker on s_tlast) produces exactly one result transaction,
// registered once, and a new byte is accepted in every cycle in which the
// output register is empty or being drained. The state update and the
// 256-entry symbol map lookup are combinational. Configuration is written
// through cfg_we, cfg_index and cfg_data and should only change while no
// transaction is in flight.
module fasta_record_parser_core
  import frp_pkg::*;
#(
  parameter int LINE_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] char_out, [11:8] error_code, [43:12] line_number
  output logic [1:0]  m_tuser,   // [1:0] item_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  parse_cfg_t           cfg;
  parse_state_t         st;
  parse_state_t         st_next;
  step_result_t         res;
  logic [LINE_COUNT_BITS-1:0] line_counter;
  logic [63:0]          line_ext;
  logic [31:0]          line_out;
  logic                 accept;

  // No transaction is taken while reset is held.
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  frp_step u_step (
    .cur           (st),
    .cfg           (cfg),
    .text_byte     (s_tdata),
    .end_of_stream (s_tlast),
    .nxt           (st_next),
    .res           (res)
  );

  // The reported line is the one holding the byte, saturated to 32 bits.
  assign line_ext = 64'(line_counter);
  assign line_out = (|line_ext[63:32]) ? 32'hFFFF_FFFF : line_ext[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.casing_mode     <= CASE_KEEP;
      cfg.validate_enable <= 1'b0;
      cfg.valid_map       <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CASING:   cfg.casing_mode <= cfg_data[1:0];
        REG_VALIDATE: cfg.validate_enable <= cfg_data[0];
        REG_MAP_0:    cfg.valid_map[63:0] <= cfg_data;
        REG_MAP_1:    cfg.valid_map[127:64] <= cfg_data;
        REG_MAP_2:    cfg.valid_map[191:128] <= cfg_data;
        REG_MAP_3:    cfg.valid_map[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= PH_START;
      st.record_has_site <= 1'b0;
      st.line_has_char   <= 1'b0;
      st.sticky_error    <= ERR_OK;
      line_counter       <= LINE_COUNT_BITS'(1);
      m_tvalid           <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
        if (res.line_inc && line_counter != '1) begin
          line_counter <= line_counter + LINE_COUNT_BITS'(1);
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= res.kind;
      m_tdata <= {4'b0000, line_out, res.error_code, res.ch};
    end
  end

`ifndef SYNTHESIS
  // Once an error is latched it never changes until reset.
  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    st.sticky_error != ERR_OK |=> st.sticky_error == $past(st.sticky_error))
    else $error("sticky error changed");

  // The line counter never moves backwards outside reset.
  a_line_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> line_counter >= $past(line_counter))
    else $error("line counter decreased");

  // A character result is never paired with an error code.
  a_kind_no_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_NONE |-> m_tdata[11:8] == ERR_OK)
    else $error("result kind with error set");

  // Nothing moves once the parse has finished or failed.
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_DONE || st.sticky_error != ERR_OK) |=> $stable(st))
    else $error("parser state moved after finishing");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for fasta_record_parser_core: feeds FASTA text through the input
// stream, predicts each result transaction and compares it field by field.
// Depends on frp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb;
  import frp_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 80;

  typedef struct packed {
    logic [7:0] text;
    logic       eos;
  } text_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [3:0]  err;
    logic [31:0] line;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
  logic        s_tlast = 1'b0;    // end_of_stream
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;           // [7:0] char_out, [11:8] error_code, [43:12] line_number
  logic [1:0]  m_tuser;           // [1:0] item_kind
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  fasta_record_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Our own copy of the registers and of the parse state.
  logic [1:0]   case_sel;
  logic         chk_en;
  logic [255:0] sym_map;
  phase_t       ph;
  logic         line_busy;
  logic [31:0]  line_cnt;
  logic [3:0]   sticky;

  text_item_t    text_q[$];
  parse_result_t expected_q[$];
  text_item_t    nxt;
  parse_result_t due;
  int            bytes_queued = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  int            stall_cycles = 0;
  int            holdoff_left = 0;
  logic          holdoff_used = 1'b0;
  wire           calm = (results_seen >= 400) && (results_seen < 520);

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (case_sel == CASE_UPPER && c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
    if (case_sel == CASE_LOWER && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic logic printable(logic [7:0] c);
    return c >= CH_PRINT_LO && c <= CH_PRINT_HI;
  endfunction

  // Advances the parse state by one byte and returns the result it yields.
  function automatic parse_result_t parse_byte(logic [7:0] c, logic eos);
    parse_result_t r;
    logic [3:0]    e;
    logic [7:0]    s;
    logic          handled;
    r.kind = KIND_NONE;
    r.ch = 8'h00;
    r.line = line_cnt;
    e = ERR_OK;
    s = fold_case(c);
    handled = 1'b0;
    if (sticky == ERR_OK && ph != PH_DONE) begin
      case (ph)
        PH_START: begin
          if (eos) ph = PH_DONE;
          else if (c == CH_GT) ph = PH_LABEL_FIRST;
          else e = ERR_NO_GT;
        end
        PH_LABEL_FIRST: begin
          if (!eos && printable(c)) begin
            r.kind = KIND_LABEL;
            r.ch = c;
            ph = PH_LABEL;
          end else begin
            e = ERR_EMPTY_LABEL;
          end
        end
        PH_LABEL: begin
          if (eos) e = ERR_BAD_LABEL_END;
          else if (printable(c)) begin
            r.kind = KIND_LABEL;
            r.ch = c;
          end else if (c == CH_NL) ph = PH_SEQ_FIRST;
          else e = ERR_BAD_LABEL_END;
        end
        PH_COMMENT: begin
          if (eos) e = ERR_NO_SEQUENCE;
          else if (c == CH_NL) ph = PH_SEQ_FIRST;
        end
        default: begin
          // The first sequence line may still turn out to be a comment.
          if (ph == PH_SEQ_FIRST && !line_busy) begin
            if (eos) begin
              e = ERR_NO_SEQUENCE;
              handled = 1'b1;
            end else if (c == CH_SEMI) begin
              ph = PH_COMMENT;
              handled = 1'b1;
            end else if (c == CH_GT) begin
              e = ERR_EMPTY_SEQUENCE;
              handled = 1'b1;
            end
          end
          if (!handled) begin
            if (!line_busy) begin
              if (eos || c == CH_GT) begin
                r.kind = KIND_RECORD_END;
                ph = eos ? PH_DONE : PH_LABEL_FIRST;
                handled = 1'b1;
              end else if (c == CH_NL) begin
                e = ERR_EMPTY_LINE;
                handled = 1'b1;
              end
            end else begin
              if (eos) begin
                e = ERR_NO_FINAL_NL;
                handled = 1'b1;
              end else if (c == CH_NL) begin
                line_busy = 1'b0;
                ph = PH_SITES;
                handled = 1'b1;
              end
            end
          end
          if (!handled) begin
            if (chk_en && !sym_map[s]) begin
              e = ERR_INVALID_SYMBOL;
            end else begin
              r.kind = KIND_SITE;
              r.ch = s;
              line_busy = 1'b1;
              ph = PH_SITES;
            end
          end
        end
      endcase
      if (e != ERR_OK) begin
        sticky = e;
        r.kind = KIND_NONE;
        r.ch = 8'h00;
      end else if (!eos && c == CH_NL && line_cnt != '1) begin
        line_cnt = line_cnt + 1;
      end
    end
    r.err = sticky;
    return r;
  endfunction

  // Sender side.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(parse_byte(s_tdata, s_tlast));
      if (!s_tvalid || s_tready) begin
        if (text_q.size() != 0 &&
            (calm || holdoff_left != 0 || $urandom_range(0, 99) >= 31)) begin
          nxt = text_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.text;
          s_tlast <= nxt.eos;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks each result transaction and drives the back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, kind %0d char %h error %0d line %0d",
                   $time, m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[43:12]);
          mismatches++;
        end else begin
          due = expected_q.pop_front();
          if (m_tuser != due.kind) begin
            $display("%0t: item_kind expected %0d, actual %0d", $time, due.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[7:0] != due.ch) begin
            $display("%0t: char_out expected %h, actual %h", $time, due.ch, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tdata[11:8] != due.err) begin
            $display("%0t: error_code expected %0d, actual %0d", $time, due.err,
                     m_tdata[11:8]);
            mismatches++;
          end
          if (m_tdata[43:12] != due.line) begin
            $display("%0t: line_number expected %0d, actual %0d", $time, due.line,
                     m_tdata[43:12]);
            mismatches++;
          end
        end
      end
      // One long hold-off lets the parser fill up and stall its input.
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else if (results_seen == 150 && !holdoff_used) begin
        holdoff_used = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || $urandom_range(0, 99) >= 31;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("fasta_record_parser_core verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_NL) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] unprintable();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 8'h1F));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  // A site byte that the parser will take as a site under the current settings.
  function automatic logic [7:0] pick_site(logic line_start, logic first_line);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_NL || (chk_en && !sym_map[fold_case(c)]) ||
           (line_start && c == CH_GT) || (line_start && first_line && c == CH_SEMI))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic push_byte(logic [7:0] c);
    text_q.push_back('{text: c, eos: 1'b0});
    bytes_queued++;
  endtask

  task automatic push_eos();
    text_q.push_back('{text: 8'($urandom_range(0, 255)), eos: 1'b1});
    bytes_queued++;
  endtask

  task automatic push_label();
    repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
  endtask

  // Comment line without its newline.
  task automatic push_comment();
    push_byte(CH_SEMI);
    repeat ($urandom_range(0, 6)) push_byte(any_but_newline());
  endtask

  task automatic gen_record();
    int n_lines;
    int n_sites;
    push_byte(CH_GT);
    push_label();
    push_byte(CH_NL);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        push_comment();
        push_byte(CH_NL);
      end
    end
    n_lines = $urandom_range(1, 3);
    for (int l = 0; l < n_lines; l++) begin
      n_sites = $urandom_range(1, 10);
      for (int i = 0; i < n_sites; i++) push_byte(pick_site(i == 0, l == 0));
      push_byte(CH_NL);
    end
  endtask

  task automatic gen_records(int target);
    int start_count;
    start_count = bytes_queued;
    while (bytes_queued - start_count < target) gen_record();
  endtask

  task automatic wait_idle();
    while (results_seen < bytes_queued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_CASING:   case_sel = data[1:0];
      REG_VALIDATE: chk_en = data[0];
      default:      sym_map[int'(idx - REG_MAP_0) * 64 +: 64] = data;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic set_mode(logic [1:0] casing, logic validate);
    write_reg(REG_CASING, (rand64() & ~64'h3) | 64'(casing));
    write_reg(REG_VALIDATE, (rand64() & ~64'h1) | 64'(validate));
  endtask

  task automatic set_maps(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2, logic [63:0] m3);
    write_reg(REG_MAP_0, m0);
    write_reg(REG_MAP_1, m1);
    write_reg(REG_MAP_2, m2);
    write_reg(REG_MAP_3, m3);
  endtask

  // The stream can end only once, so each run picks one way of ending it.
  task automatic finish_stream();
    logic [3:0] ending;
    logic [7:0] c;
    logic [7:0] s;
    ending = 4'($urandom_range(0, 8));
    case (ending)
      ERR_EMPTY_LABEL: begin
        push_byte(CH_GT);
        if ($urandom_range(0, 1) == 0) push_eos();
        else push_byte(unprintable());
      end
      ERR_BAD_LABEL_END: begin
        push_byte(CH_GT);
        push_label();
        if ($urandom_range(0, 1) == 0) begin
          push_eos();
        end else begin
          c = unprintable();
          while (c == CH_NL) c = unprintable();
          push_byte(c);
        end
      end
      ERR_NO_SEQUENCE: begin
        push_byte(CH_GT);
        push_label();
        push_byte(CH_NL);
        if ($urandom_range(0, 1) == 0) push_comment();
        push_eos();
      end
      ERR_INVALID_SYMBOL: begin
        wait_idle();
        write_reg(REG_VALIDATE, 64'd1);
        c = 8'($urandom_range(0, 255));
        while (c == CH_NL || c == CH_GT) c = 8'($urandom_range(0, 255));
        s = fold_case(c);
        write_reg(3'(REG_MAP_0 + s[7:6]), sym_map[s[7:6] * 64 +: 64] & ~(64'd1 << s[5:0]));
        push_byte(c);
      end
      ERR_EMPTY_LINE: push_byte(CH_NL);
      ERR_NO_FINAL_NL: begin
        push_byte(pick_site(1'b1, 1'b0));
        push_eos();
      end
      ERR_EMPTY_SEQUENCE: begin
        push_byte(CH_GT);
        push_label();
        push_byte(CH_NL);
        if ($urandom_range(0, 1) == 0) begin
          push_comment();
          push_byte(CH_NL);
        end
        push_byte(CH_GT);
      end
      // A missing '>' can only occur at the very start, so it ends cleanly too.
      default: push_eos();
    endcase
    // Whatever follows must leave the frozen outputs alone.
    repeat (8) begin
      if ($urandom_range(0, 3) == 0) push_eos();
      else push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] opening[$];
    // Label and site extremes, comments (one empty), a '>' and a ';' inside sequence
    // lines, then a second record.
    opening = '{CH_GT, 8'h20, 8'h7E, CH_NL, CH_SEMI, 8'h00, 8'hFF, CH_NL, CH_SEMI, CH_NL,
                8'h00, 8'hFF, CH_GT, CH_SEMI, CH_NL, CH_SEMI, 8'h61, 8'h5A, CH_NL,
                CH_GT, 8'h71, CH_NL, 8'h78, CH_NL};
    case_sel = CASE_KEEP;
    chk_en = 1'b0;
    sym_map = '1;
    ph = PH_START;
    line_busy = 1'b0;
    line_cnt = 32'd1;
    sticky = ERR_OK;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) push_byte(opening[i]);
    gen_records(110);

    wait_idle();
    set_mode(CASE_UPPER, 1'b0);
    set_maps(64'd0, 64'd0, 64'd0, 64'd0);
    gen_records(120);

    wait_idle();
    set_mode(CASE_LOWER, 1'b1);
    set_maps(rand64(), '1, rand64(), 64'd0);
    gen_records(120);

    // Code 3 is unused and keeps the case.
    wait_idle();
    set_mode(2'd3, 1'b1);
    set_maps('1, rand64(), 64'd0, rand64());
    gen_records(120);

    wait_idle();
    set_mode(CASE_KEEP, 1'b1);
    set_maps(rand64(), rand64(), rand64(), rand64());
    gen_records(120);

    wait_idle();
    set_mode(2'($urandom_range(0, 3)), 1'b0);
    gen_records(120);

    finish_stream();
    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_q.size());
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("fasta_record_parser_core verification clean");
    end else begin
      $display("fasta_record_parser_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/frp_pkg.sv
hw/rtl/frp_step.sv
hw/rtl/fasta_record_parser_core.sv
bench/tb.sv
